[rtl/rvcfp_pkg.sv]
// rvcfp_pkg: shared types, codes and immediate helpers of the fetch predecoder
// no dependencies
`default_nettype none
package rvcfp_pkg;

  localparam logic OPC_FETCH = 1'b0;
  localparam logic OPC_FLUSH = 1'b1;

  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [2:0] F3_JALR   = 3'b000;
  localparam logic [2:0] F3_CJ     = 3'b101;
  localparam logic [2:0] F3_CBEQZ  = 3'b110;
  localparam logic [2:0] F3_CBNEZ  = 3'b111;
  localparam logic [1:0] Q_FULL    = 2'b11;
  localparam logic [1:0] Q_C1      = 2'b01;

  typedef enum logic [1:0] {
    KIND_PACKET,
    KIND_FAULT,
    KIND_FLUSH
  } item_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [63:0]       fetch_address;
    logic [63:0]       packet_bytes;
    logic [3:0]        fault_cause;
    logic [3:0]        tk_valid;
    logic [3:0]        tk;
    logic [3:0]        tgt_valid;
    logic [3:0][63:0]  pred_target;
  } fetch_item_t;

  typedef struct packed {
    logic [63:0] insn_pc;
    logic [31:0] insn_word;
    logic        is_compressed;
    logic        fault_out;
    logic [3:0]  fault_cause_out;
    logic        predicted_taken;
    logic [63:0] predicted_target;
    logic        redirect;
    logic        wait_resume;
    logic        last;
  } result_t;

  function automatic logic [63:0] imm_j(input logic [31:0] w);
    return {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  endfunction

  function automatic logic [63:0] imm_b(input logic [31:0] w);
    return {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  endfunction

  function automatic logic [63:0] imm_cj(input logic [31:0] w);
    return {{52{w[12]}}, w[12], w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
  endfunction

  function automatic logic [63:0] imm_cb(input logic [31:0] w);
    return {{55{w[12]}}, w[12], w[6:5], w[2], w[11:10], w[4:3], 1'b0};
  endfunction

endpackage
`default_nettype wire

[rtl/rvcfp_front.sv]
// rvcfp_front: accepts fetch items, classifies them and queues them (two entries)
// depends on rvcfp_pkg
`default_nettype none
module rvcfp_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  in_opcode,
  input  wire                  in_fault_valid,
  input  rvcfp_pkg::fetch_item_t in_item,
  output logic                 head_valid,
  output rvcfp_pkg::fetch_item_t head,
  input  wire                  head_pop
);
  import rvcfp_pkg::*;

  fetch_item_t mem_r [2];
  fetch_item_t item_cls;
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic        push;

  always_comb begin
    item_cls = in_item;
    if (in_opcode == OPC_FLUSH) begin
      item_cls.kind = KIND_FLUSH;
    end else if (in_fault_valid) begin
      item_cls.kind = KIND_FAULT;
    end else begin
      item_cls.kind = KIND_PACKET;
    end
  end

  assign in_ready   = (count_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (head_pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(head_pop);
    end
  end

endmodule
`default_nettype wire

[rtl/rvcfp_back.sv]
// rvcfp_back: walks a queued packet one instruction a cycle while not
// stalled by the output, predicts and checks control flow, holds the
// split half and the result register; depends on rvcfp_pkg
`default_nettype none
module rvcfp_back #(
  parameter int FETCH_BYTES = 8,
  parameter int ALIGN_BYTES = 8
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    head_valid,
  input  rvcfp_pkg::fetch_item_t head,
  output logic                   head_pop,
  output logic                   out_valid,
  input  wire                    out_ready,
  output rvcfp_pkg::result_t     out_res
);
  import rvcfp_pkg::*;

  localparam int NH       = (FETCH_BYTES / 2 > 4) ? 4 : FETCH_BYTES / 2;
  localparam int OFF_BITS = $clog2(ALIGN_BYTES);
  localparam logic [2:0] NH3 = 3'(NH);

  logic        pend_r, pend_nxt;
  logic [15:0] plow_r, plow_nxt;
  logic        first_r, first_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [63:0] pc_r, pc_nxt;
  logic [1:0]  n_r, n_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_r, out_nxt;

  logic [3:0][15:0] hw;
  logic        go, pend_eff, emit, is_rvc, is_held, more, held_next, taken, redir;
  logic        tv, tk, gv;
  logic [2:0]  off, pos, npos;
  logic [1:0]  slot;
  logic [63:0] pc, len, tgt, ptgt, npc;
  logic [31:0] w;
  logic [15:0] h, h2, hn;

  assign hw = head.packet_bytes;
  assign go = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    off      = 3'(head.fetch_address[OFF_BITS-1:0] >> 1);
    pend_eff = pend_r && !(first_r && off != 3'd0);
    pos      = first_r ? off : pos_r;
    pc       = first_r ? ((head.fetch_address & ~64'd1) - (pend_eff ? 64'd2 : 64'd0))
                       : pc_r;
    slot     = pos[1:0];
    h        = hw[slot];
    h2       = hw[slot + 2'd1];
    is_rvc   = 1'b0;
    is_held  = 1'b0;
    w        = {h2, h};
    npos     = pos + 3'd2;
    if (pend_eff) begin
      w    = {h, plow_r};
      npos = pos + 3'd1;
    end else if (h[1:0] != Q_FULL) begin
      w      = {16'd0, h};
      is_rvc = 1'b1;
      npos   = pos + 3'd1;
    end else if (pos + 3'd1 >= NH3) begin
      is_held = 1'b1;
    end
    tv    = head.tk_valid[slot];
    tk    = head.tk[slot];
    gv    = head.tgt_valid[slot];
    ptgt  = head.pred_target[slot];
    len   = is_rvc ? 64'd2 : 64'd4;
    npc   = pc + len;
    taken = 1'b0;
    tgt   = npc;
    redir = 1'b0;
    if (w[6:0] == OP_JAL) begin
      taken = 1'b1;
      tgt   = pc + imm_j(w);
      redir = !(tv && tk && gv && ptgt == tgt);
    end else if (w[6:0] == OP_JALR && w[14:12] == F3_JALR) begin
      if (tv && gv) begin
        taken = tk;
        tgt   = ptgt;
      end
    end else if (w[6:0] == OP_BRANCH) begin
      if (tv && tk) begin
        taken = 1'b1;
        tgt   = pc + imm_b(w);
        redir = !(gv && ptgt == tgt);
      end
    end else if (w[1:0] == Q_C1) begin
      if (w[15:13] == F3_CJ) begin
        taken = 1'b1;
        tgt   = pc + imm_cj(w);
        redir = !(tv && tk && gv && ptgt == tgt);
      end else if (w[15:13] == F3_CBEQZ || w[15:13] == F3_CBNEZ) begin
        if (tv && tk) begin
          taken = 1'b1;
          tgt   = pc + imm_cb(w);
          redir = !(gv && ptgt == tgt);
        end
      end
    end else begin
      redir = tv && gv;
    end
    hn        = hw[npos[1:0]];
    held_next = !redir && (npos < NH3) && (hn[1:0] == Q_FULL) && (npos + 3'd1 >= NH3);
    more      = !redir && (n_r != 2'd3) && (npos < NH3) &&
                !((hn[1:0] == Q_FULL) && (npos + 3'd1 >= NH3));
  end

  always_comb begin
    pend_nxt      = pend_r;
    plow_nxt      = plow_r;
    first_nxt     = first_r;
    pos_nxt       = pos_r;
    pc_nxt        = pc_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    head_pop      = 1'b0;
    emit          = 1'b0;
    if (go) begin
      case (head.kind)
        KIND_FLUSH: begin
          pend_nxt = 1'b0;
          plow_nxt = 16'd0;
          head_pop = 1'b1;
        end
        KIND_FAULT: begin
          out_nxt                 = '0;
          out_nxt.insn_pc         = head.fetch_address;
          out_nxt.fault_out       = 1'b1;
          out_nxt.fault_cause_out = head.fault_cause;
          out_nxt.wait_resume     = 1'b1;
          out_nxt.last            = 1'b1;
          out_valid_nxt           = 1'b1;
          head_pop                = 1'b1;
        end
        KIND_PACKET: begin
          pend_nxt = pend_eff;
          if (pend_eff) plow_nxt = 16'd0;
          if (pos >= NH3) begin
            head_pop = 1'b1;
          end else if (is_held) begin
            pend_nxt = 1'b1;
            plow_nxt = h;
            head_pop = 1'b1;
          end else begin
            emit     = 1'b1;
            if (pend_eff) pend_nxt = 1'b0;
            if (redir) begin
              pend_nxt = 1'b0;
              plow_nxt = 16'd0;
            end
            // packet ends in the low half of a split instruction
            if (held_next) begin
              pend_nxt = 1'b1;
              plow_nxt = hn;
            end
            head_pop = !more;
            pos_nxt  = npos;
            pc_nxt   = npc;
            n_nxt    = n_r + 2'd1;
          end
        end
        default: head_pop = 1'b1;
      endcase
      if (head_pop) begin
        first_nxt = 1'b1;
        n_nxt     = 2'd0;
      end else begin
        first_nxt = 1'b0;
      end
    end
    if (emit) begin
      out_nxt                  = '0;
      out_nxt.insn_pc          = pc;
      out_nxt.insn_word        = w;
      out_nxt.is_compressed    = is_rvc;
      out_nxt.predicted_taken  = taken;
      out_nxt.predicted_target = tgt;
      out_nxt.redirect         = redir;
      out_nxt.last             = !more;
      out_valid_nxt            = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      plow_r      <= 16'd0;
      first_r     <= 1'b1;
      pos_r       <= 3'd0;
      pc_r        <= 64'd0;
      n_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      plow_r      <= plow_nxt;
      first_r     <= first_nxt;
      pos_r       <= pos_nxt;
      pc_r        <= pc_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_fault_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.fault_out) |-> out_r.last) else $error("fault result not last");
  a_redir_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.redirect) |-> out_r.last) else $error("redirect not last");
  a_redir_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && redir) |=> !pend_r) else $error("held half kept after redirect");
  a_rvc_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.is_compressed) |-> (out_r.insn_word[31:16] == 16'd0))
    else $error("compressed word not zero-extended");

endmodule
`default_nettype wire

[rtl/rvc_fetch_predecode_redirect.sv]
// rvc_fetch_predecode_redirect: top level of the fetch predecoder
// depends on rvcfp_pkg, rvcfp_front, rvcfp_back
//
// Splits each fetch packet into 16-bit and 32-bit instructions and delivers one
// result per cycle from a registered output unless out_ready holds it; a packet
// yields up to four instructions, and the back stage walks them in order before
// it takes the next queued item. The walk over the packet in the back stage sets
// this rate; a two-entry queue lets the input side keep accepting while results
// wait. Flush items produce no result.
`default_nettype none
module rvc_fetch_predecode_redirect #(
  parameter int FETCH_BYTES = 8,
  parameter int ALIGN_BYTES = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_opcode,
  input  wire  [63:0] in_fetch_address,
  input  wire  [63:0] in_packet_bytes,
  input  wire         in_fault_valid,
  input  wire  [3:0]  in_fault_cause,
  input  wire  [3:0]  in_pred_taken_valid_mask,
  input  wire  [3:0]  in_pred_taken_mask,
  input  wire  [3:0]  in_pred_target_valid_mask,
  input  wire  [63:0] in_pred_target_slot0,
  input  wire  [63:0] in_pred_target_slot1,
  input  wire  [63:0] in_pred_target_slot2,
  input  wire  [63:0] in_pred_target_slot3,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] out_insn_pc,
  output logic [31:0] out_insn_word,
  output logic        out_is_compressed,
  output logic        out_fault_out,
  output logic [3:0]  out_fault_cause_out,
  output logic        out_predicted_taken,
  output logic [63:0] out_predicted_target,
  output logic        out_redirect,
  output logic        out_wait_resume,
  output logic        out_last
);
  import rvcfp_pkg::*;

  fetch_item_t in_item, head;
  logic        head_valid, head_pop;
  result_t     res;

  always_comb begin
    in_item.kind          = KIND_PACKET;
    in_item.fetch_address = in_fetch_address;
    in_item.packet_bytes  = in_packet_bytes;
    in_item.fault_cause   = in_fault_cause;
    in_item.tk_valid      = in_pred_taken_valid_mask;
    in_item.tk            = in_pred_taken_mask;
    in_item.tgt_valid     = in_pred_target_valid_mask;
    in_item.pred_target   = {in_pred_target_slot3, in_pred_target_slot2,
                             in_pred_target_slot1, in_pred_target_slot0};
  end

  rvcfp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_fault_valid (in_fault_valid),
    .in_item        (in_item),
    .head_valid     (head_valid),
    .head           (head),
    .head_pop       (head_pop)
  );

  rvcfp_back #(
    .FETCH_BYTES (FETCH_BYTES),
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (res)
  );

  assign out_insn_pc          = res.insn_pc;
  assign out_insn_word        = res.insn_word;
  assign out_is_compressed    = res.is_compressed;
  assign out_fault_out        = res.fault_out;
  assign out_fault_cause_out  = res.fault_cause_out;
  assign out_predicted_taken  = res.predicted_taken;
  assign out_predicted_target = res.predicted_target;
  assign out_redirect         = res.redirect;
  assign out_wait_resume      = res.wait_resume;
  assign out_last             = res.last;

endmodule
`default_nettype wire
